@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/tch_pkg.sv @@
// ----------------------------------------------------------------------------
// tch_pkg
// Types, constants and the arctangent table of the tilt-compensated heading.
// ----------------------------------------------------------------------------
`default_nettype none

package tch_pkg;

    localparam int SAMPLE_W             = 16;
    localparam int HEADING_W            = 15;
    localparam int STATUS_W             = 2;
    localparam int ANG_BITS             = 16;
    localparam int CORDIC_STEPS         = 18;
    localparam int STEP_W               = 5;
    localparam int CORDIC_W             = 52;
    localparam int Z_W                  = 27;
    localparam int ZPOS_W               = 25;
    localparam int QUOT_W               = 16;
    localparam int NUM_CFG              = 6;
    localparam int CFG_ADDR_W           = 5;
    localparam int CFG_IDX_W            = 3;
    localparam int APB_DATA_W           = 32;
    localparam int DEF_HEADING_FRAC_BITS = 6;
    localparam int DEF_QUEUE_DEPTH      = 2;

    localparam logic signed [Z_W-1:0] HALF_TURN = 27'sd11796480;
    localparam logic signed [Z_W-1:0] FULL_TURN = 27'sd23592960;

    localparam logic signed [CORDIC_W-1:0] NORM_COARSE =
        CORDIC_W'(64'h0000_0080_0000_0000);
    localparam logic signed [CORDIC_W-1:0] NORM_TARGET =
        CORDIC_W'(64'h0000_4000_0000_0000);

    localparam logic signed [SAMPLE_W-1:0] CAL_POS_SAT = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] CAL_NEG_SAT = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] CFG_MIN_RESET = -16'sd2048;
    localparam logic signed [SAMPLE_W-1:0] CFG_MAX_RESET = 16'sd2047;

    localparam logic [CFG_IDX_W-1:0] REG_MAG_X_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_X_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_Y_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_Y_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_Z_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_Z_MAX = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_SPAN     = 2'd1,
        STAT_ZERO_VEC = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mag_x_min;
        logic signed [SAMPLE_W-1:0] mag_x_max;
        logic signed [SAMPLE_W-1:0] mag_y_min;
        logic signed [SAMPLE_W-1:0] mag_y_max;
        logic signed [SAMPLE_W-1:0] mag_z_min;
        logic signed [SAMPLE_W-1:0] mag_z_max;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] cal_x;
        logic signed [SAMPLE_W-1:0] cal_y;
        logic signed [SAMPLE_W-1:0] cal_z;
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        t_status                    status;
    } t_cal_item;

    // Arctangent of 2^-i in units of 2^-16 degree.
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tch_front.sv @@
// ----------------------------------------------------------------------------
// tch_front
// Takes raw samples and calibrates the three magnetometer axes with a
// shared-schedule restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  tch_pkg::t_cfg                    i_cfg,
    input  wire                              i_push,
    output logic                             o_full,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_accel_x,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_accel_y,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_accel_z,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_mag_x,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_mag_y,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_mag_z,
    output logic                             o_q_push,
    output tch_pkg::t_cal_item               o_q_item,
    input  wire                              i_q_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    localparam int AN_W  = 32;
    localparam int REM_W = 33;
    localparam int DSH_W = 31;

    t_fstate r_state, n_state;

    logic                              r_hold_valid;
    logic signed [tch_pkg::SAMPLE_W-1:0] r_hold_acc [3];
    logic signed [tch_pkg::SAMPLE_W-1:0] r_hold_mag [3];

    logic signed [tch_pkg::SAMPLE_W-1:0] r_acc [3];
    logic [REM_W-1:0]                  r_rem [3];
    logic [DSH_W-1:0]                  r_dsh [3];
    logic [tch_pkg::QUOT_W-1:0]        r_quot [3];
    logic                              r_neg [3];
    logic                              r_span_err;
    logic [3:0]                        r_step;

    logic signed [tch_pkg::SAMPLE_W-1:0] s_lo [3];
    logic signed [tch_pkg::SAMPLE_W-1:0] s_hi [3];
    logic [16:0]                       s_span [3];
    logic [16:0]                       s_diff [3];
    logic [18:0]                       s_t [3];
    logic [18:0]                       s_t_neg [3];
    logic [16:0]                       s_span_neg [3];
    logic [15:0]                       s_ad [3];
    logic [AN_W-1:0]                   s_an [3];
    logic [REM_W-1:0]                  s_num [3];
    logic                              s_neg [3];
    logic                              s_span_zero;
    logic signed [tch_pkg::SAMPLE_W-1:0] s_cal [3];
    logic                              s_accept;
    logic                              s_load;

    assign s_lo[0] = i_cfg.mag_x_min;
    assign s_hi[0] = i_cfg.mag_x_max;
    assign s_lo[1] = i_cfg.mag_y_min;
    assign s_hi[1] = i_cfg.mag_y_max;
    assign s_lo[2] = i_cfg.mag_z_min;
    assign s_hi[2] = i_cfg.mag_z_max;

    assign s_accept = i_push && !r_hold_valid;
    assign o_full   = r_hold_valid;
    assign s_load   = (r_state == F_IDLE) && r_hold_valid;

    // Numerator (2*(m - min) - span) * 2^14 and its rounding offset.
    always_comb begin
        s_span_zero = 1'b0;
        for (int k = 0; k < 3; k++) begin
            s_span[k]     = {s_hi[k][15], s_hi[k]} - {s_lo[k][15], s_lo[k]};
            s_diff[k]     = {r_hold_mag[k][15], r_hold_mag[k]} - {s_lo[k][15], s_lo[k]};
            s_t[k]        = {s_diff[k][16], s_diff[k], 1'b0}
                            - {{2{s_span[k][16]}}, s_span[k]};
            s_t_neg[k]    = -s_t[k];
            s_span_neg[k] = -s_span[k];
            s_neg[k]      = s_t[k][18] ^ s_span[k][16];
            s_ad[k]       = s_span[k][16] ? s_span_neg[k][15:0] : s_span[k][15:0];
            s_an[k]       = {(s_t[k][18] ? s_t_neg[k][17:0] : s_t[k][17:0]), 14'b0};
            s_num[k]      = {1'b0, s_an[k]} + {18'b0, s_ad[k][15:1]};
            if (s_span[k] == 17'd0) begin
                s_span_zero = 1'b1;
            end
        end
    end

    // A set top quotient bit means the result is beyond the Q2.14 range.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_quot[k][tch_pkg::QUOT_W-1]) begin
                s_cal[k] = r_neg[k] ? tch_pkg::CAL_NEG_SAT : tch_pkg::CAL_POS_SAT;
            end else if (r_neg[k]) begin
                s_cal[k] = -$signed({1'b0, r_quot[k][tch_pkg::QUOT_W-2:0]});
            end else begin
                s_cal[k] = $signed({1'b0, r_quot[k][tch_pkg::QUOT_W-2:0]});
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (r_hold_valid) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (r_step == 4'd0) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
        endcase
    end

    assign o_q_push          = (r_state == F_PUSH) && !i_q_full;
    assign o_q_item.cal_x    = s_cal[0];
    assign o_q_item.cal_y    = s_cal[1];
    assign o_q_item.cal_z    = s_cal[2];
    assign o_q_item.accel_x  = r_acc[0];
    assign o_q_item.accel_y  = r_acc[1];
    assign o_q_item.accel_z  = r_acc[2];
    assign o_q_item.status   = r_span_err ? tch_pkg::STAT_SPAN : tch_pkg::STAT_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_hold_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_accept) begin
                r_hold_valid <= 1'b1;
            end else if (s_load) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_hold_acc[0] <= i_accel_x;
            r_hold_acc[1] <= i_accel_y;
            r_hold_acc[2] <= i_accel_z;
            r_hold_mag[0] <= i_mag_x;
            r_hold_mag[1] <= i_mag_y;
            r_hold_mag[2] <= i_mag_z;
        end
        if (s_load) begin
            r_span_err <= s_span_zero;
            r_step     <= 4'd15;
            for (int k = 0; k < 3; k++) begin
                r_acc[k]  <= r_hold_acc[k];
                r_rem[k]  <= s_num[k];
                r_dsh[k]  <= {s_ad[k], 15'b0};
                r_quot[k] <= '0;
                r_neg[k]  <= s_neg[k];
            end
        end else if (r_state == F_DIV) begin
            r_step <= r_step - 4'd1;
            for (int k = 0; k < 3; k++) begin
                if (r_rem[k] >= {2'b0, r_dsh[k]}) begin
                    r_rem[k]  <= r_rem[k] - {2'b0, r_dsh[k]};
                    r_quot[k] <= {r_quot[k][tch_pkg::QUOT_W-2:0], 1'b1};
                end else begin
                    r_quot[k] <= {r_quot[k][tch_pkg::QUOT_W-2:0], 1'b0};
                end
                r_dsh[k] <= r_dsh[k] >> 1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tch_queue.sv @@
// ----------------------------------------------------------------------------
// tch_queue
// Small FIFO of calibrated samples between the front and back sections.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_queue #(
    parameter int DEPTH = tch_pkg::DEF_QUEUE_DEPTH
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  tch_pkg::t_cal_item i_item,
    output logic               o_full,
    input  wire                i_pop,
    output tch_pkg::t_cal_item o_item,
    output logic               o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tch_pkg::t_cal_item r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               s_wr_en;
    logic               s_rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign s_wr_en = i_push && !o_full;
    assign s_rd_en = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (s_wr_en) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (s_rd_en) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (s_wr_en && !s_rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (s_rd_en && !s_wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tch_back.sv @@
// ----------------------------------------------------------------------------
// tch_back
// Forms east and north from the calibrated sample and turns them into a
// heading with a normalizer and an iterative CORDIC vectoring unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_back #(
    parameter int HEADING_FRAC_BITS = tch_pkg::DEF_HEADING_FRAC_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_q_empty,
    output logic                             o_q_pop,
    input  tch_pkg::t_cal_item               i_q_item,
    output logic                             o_empty,
    input  wire                              i_pop,
    output logic [tch_pkg::HEADING_W-1:0]    o_heading,
    output logic [tch_pkg::STATUS_W-1:0]     o_status
);

    typedef enum logic [7:0] {
        B_IDLE = 8'b0000_0001,
        B_MUL1 = 8'b0000_0010,
        B_MUL2 = 8'b0000_0100,
        B_PREP = 8'b0000_1000,
        B_NORM = 8'b0001_0000,
        B_ITER = 8'b0010_0000,
        B_WRAP = 8'b0100_0000,
        B_DONE = 8'b1000_0000
    } t_bstate;

    localparam int CW    = tch_pkg::CORDIC_W;
    localparam int SUM_W = tch_pkg::ZPOS_W + HEADING_FRAC_BITS + 1;

    t_bstate r_state;

    tch_pkg::t_cal_item       r_item;
    tch_pkg::t_status         r_status;
    logic signed [32:0]       r_ex;
    logic signed [32:0]       r_ey;
    logic signed [32:0]       r_ez;
    logic signed [CW-1:0]     r_x;
    logic signed [CW-1:0]     r_y;
    logic signed [tch_pkg::Z_W-1:0] r_z;
    logic [tch_pkg::STEP_W-1:0] r_i;
    logic                     r_out_valid;
    logic [tch_pkg::HEADING_W-1:0] r_out_heading;
    tch_pkg::t_status         r_out_status;

    logic signed [31:0]       s_p0, s_p1, s_p2, s_p3, s_p4, s_p5;
    logic signed [48:0]       s_q0, s_q1;
    logic signed [49:0]       s_ny;
    logic signed [CW-1:0]     s_abs_y;
    logic signed [CW-1:0]     s_mx;
    logic signed [CW-1:0]     s_xs;
    logic signed [CW-1:0]     s_ys;
    logic signed [tch_pkg::Z_W-1:0] s_atan;
    logic [SUM_W-1:0]         s_hsum;
    logic [SUM_W-1:0]         s_hval;
    logic [SUM_W-1:0]         s_hwrap;
    logic                     s_out_free;

    // East = M x A, registered before the difference of north.
    assign s_p0 = r_item.cal_y * r_item.accel_z;
    assign s_p1 = r_item.cal_z * r_item.accel_y;
    assign s_p2 = r_item.cal_z * r_item.accel_x;
    assign s_p3 = r_item.cal_x * r_item.accel_z;
    assign s_p4 = r_item.cal_x * r_item.accel_y;
    assign s_p5 = r_item.cal_y * r_item.accel_x;

    assign s_q0 = r_item.accel_z * r_ex;
    assign s_q1 = r_item.accel_x * r_ez;
    assign s_ny = 50'(s_q0) - 50'(s_q1);

    assign s_abs_y = r_y[CW-1] ? -r_y : r_y;
    assign s_mx    = (r_x > s_abs_y) ? r_x : s_abs_y;
    assign s_xs    = r_x >>> r_i;
    assign s_ys    = r_y >>> r_i;
    assign s_atan  = tch_pkg::atan_entry(r_i);

    // Round half up from 2^-16 degree to the output scale; a full turn is zero.
    assign s_hsum  = (SUM_W'(r_z[tch_pkg::ZPOS_W-1:0]) << HEADING_FRAC_BITS)
                     + (SUM_W'(1) << (tch_pkg::ANG_BITS - 1));
    assign s_hval  = s_hsum >> tch_pkg::ANG_BITS;
    assign s_hwrap = (s_hval >= (SUM_W'(360) << HEADING_FRAC_BITS))
                     ? s_hval - (SUM_W'(360) << HEADING_FRAC_BITS) : s_hval;

    assign s_out_free = !r_out_valid || i_pop;
    assign o_q_pop    = (r_state == B_IDLE) && !i_q_empty;
    assign o_empty    = !r_out_valid;
    assign o_heading  = r_out_heading;
    assign o_status   = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == B_DONE && s_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= (i_q_item.status == tch_pkg::STAT_SPAN) ? B_WRAP : B_MUL1;
                    end
                end
                B_MUL1: r_state <= B_MUL2;
                B_MUL2: begin
                    if (r_ex == '0 && r_ey == '0 && r_ez == '0) begin
                        r_state <= B_WRAP;
                    end else begin
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    if (r_x == '0 && r_y == '0) begin
                        r_state <= B_WRAP;
                    end else begin
                        r_state <= B_NORM;
                    end
                end
                B_NORM: begin
                    if (s_mx >= tch_pkg::NORM_TARGET) begin
                        r_state <= B_ITER;
                    end
                end
                B_ITER: begin
                    if (r_i == tch_pkg::STEP_W'(tch_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= B_WRAP;
                    end
                end
                B_WRAP: r_state <= B_DONE;
                B_DONE: begin
                    if (s_out_free) begin
                        r_state <= B_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_item   <= i_q_item;
                r_status <= i_q_item.status;
                r_z      <= '0;
            end
            B_MUL1: begin
                r_ex <= 33'(s_p0) - 33'(s_p1);
                r_ey <= 33'(s_p2) - 33'(s_p3);
                r_ez <= 33'(s_p4) - 33'(s_p5);
            end
            B_MUL2: begin
                if (r_ex == '0 && r_ey == '0 && r_ez == '0) begin
                    r_status <= tch_pkg::STAT_ZERO_VEC;
                end
                r_x <= -(CW'(s_ny));
                r_y <= -(CW'(r_ey));
            end
            B_PREP: begin
                if (r_x[CW-1]) begin
                    r_x <= -r_x;
                    r_y <= -r_y;
                    r_z <= tch_pkg::HALF_TURN;
                end
            end
            B_NORM: begin
                r_i <= '0;
                if (s_mx < tch_pkg::NORM_COARSE) begin
                    r_x <= r_x <<< 8;
                    r_y <= r_y <<< 8;
                end else if (s_mx < tch_pkg::NORM_TARGET) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end
            B_ITER: begin
                r_i <= r_i + 1'b1;
                if (!r_y[CW-1]) begin
                    r_x <= r_x + s_ys;
                    r_y <= r_y - s_xs;
                    r_z <= r_z + s_atan;
                end else begin
                    r_x <= r_x - s_ys;
                    r_y <= r_y + s_xs;
                    r_z <= r_z - s_atan;
                end
            end
            B_WRAP: begin
                if (r_z[tch_pkg::Z_W-1]) begin
                    r_z <= r_z + tch_pkg::FULL_TURN;
                end else if (r_z >= tch_pkg::FULL_TURN) begin
                    r_z <= r_z - tch_pkg::FULL_TURN;
                end
            end
            B_DONE: begin
                if (s_out_free) begin
                    r_out_heading <= s_hwrap[tch_pkg::HEADING_W-1:0];
                    r_out_status  <= r_status;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/tilt_compensated_heading.sv @@
// ----------------------------------------------------------------------------
// Tilt-compensated compass heading.
// Input queue side: drive the six raw sensor fields and raise push; a sample
// is taken at a clock edge where push is high and full is low. A one-sample
// holding register lets a new sample in while the previous one is calibrated.
// Result queue side: while empty is low, o_heading (1/64 degree by default)
// and o_status are valid; pop takes them. A stalled result holds in the
// output register while the CORDIC section already works on the next sample.
// Calibration uses a restoring divider at one quotient bit per cycle; the
// heading section (a normalizer of up to 12 steps, then 18 CORDIC steps)
// is the slower one and sets the sustained rate. Error cases (zero
// calibration span, zero-length east vector) finish early. The user must
// write calibration limits over the APB port only while the block is idle;
// the block itself does not enforce this. Synchronous reset empties all
// queues and loads the default limits of -2048 and 2047 on every axis.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tilt_compensated_heading #(
    parameter int HEADING_FRAC_BITS = tch_pkg::DEF_HEADING_FRAC_BITS,
    parameter int QUEUE_DEPTH       = tch_pkg::DEF_QUEUE_DEPTH
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [tch_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire [tch_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tch_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  wire                                push,
    output logic                               full,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_accel_x,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_accel_y,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_accel_z,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_mag_x,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_mag_y,
    input  wire signed [tch_pkg::SAMPLE_W-1:0] i_mag_z,
    output logic                               empty,
    input  wire                                pop,
    output logic [tch_pkg::HEADING_W-1:0]      o_heading,
    output logic [tch_pkg::STATUS_W-1:0]       o_status
);

    tch_pkg::t_cfg      r_cfg;
    tch_pkg::t_cal_item s_front_item;
    tch_pkg::t_cal_item s_back_item;
    logic               s_q_push;
    logic               s_q_full;
    logic               s_q_pop;
    logic               s_q_empty;
    logic [tch_pkg::CFG_IDX_W-1:0] s_idx;
    logic signed [tch_pkg::SAMPLE_W-1:0] s_rd_val;
    logic signed [tch_pkg::SAMPLE_W-1:0] s_wr_val;
    logic               s_cfg_wr;
    logic               s_err_nonzero;

    assign pready   = 1'b1;
    assign s_idx    = paddr[tch_pkg::CFG_ADDR_W-1:2];
    assign s_wr_val = pwdata[tch_pkg::SAMPLE_W-1:0];
    assign s_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (s_idx)
            tch_pkg::REG_MAG_X_MIN: s_rd_val = r_cfg.mag_x_min;
            tch_pkg::REG_MAG_X_MAX: s_rd_val = r_cfg.mag_x_max;
            tch_pkg::REG_MAG_Y_MIN: s_rd_val = r_cfg.mag_y_min;
            tch_pkg::REG_MAG_Y_MAX: s_rd_val = r_cfg.mag_y_max;
            tch_pkg::REG_MAG_Z_MIN: s_rd_val = r_cfg.mag_z_min;
            tch_pkg::REG_MAG_Z_MAX: s_rd_val = r_cfg.mag_z_max;
            default:                s_rd_val = '0;
        endcase
    end

    assign prdata = tch_pkg::APB_DATA_W'(s_rd_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mag_x_min <= tch_pkg::CFG_MIN_RESET;
            r_cfg.mag_x_max <= tch_pkg::CFG_MAX_RESET;
            r_cfg.mag_y_min <= tch_pkg::CFG_MIN_RESET;
            r_cfg.mag_y_max <= tch_pkg::CFG_MAX_RESET;
            r_cfg.mag_z_min <= tch_pkg::CFG_MIN_RESET;
            r_cfg.mag_z_max <= tch_pkg::CFG_MAX_RESET;
        end else if (s_cfg_wr) begin
            case (s_idx)
                tch_pkg::REG_MAG_X_MIN: r_cfg.mag_x_min <= s_wr_val;
                tch_pkg::REG_MAG_X_MAX: r_cfg.mag_x_max <= s_wr_val;
                tch_pkg::REG_MAG_Y_MIN: r_cfg.mag_y_min <= s_wr_val;
                tch_pkg::REG_MAG_Y_MAX: r_cfg.mag_y_max <= s_wr_val;
                tch_pkg::REG_MAG_Z_MIN: r_cfg.mag_z_min <= s_wr_val;
                tch_pkg::REG_MAG_Z_MAX: r_cfg.mag_z_max <= s_wr_val;
                default: ;
            endcase
        end
    end

    tch_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_push    (push),
        .o_full    (full),
        .i_accel_x (i_accel_x),
        .i_accel_y (i_accel_y),
        .i_accel_z (i_accel_z),
        .i_mag_x   (i_mag_x),
        .i_mag_y   (i_mag_y),
        .i_mag_z   (i_mag_z),
        .o_q_push  (s_q_push),
        .o_q_item  (s_front_item),
        .i_q_full  (s_q_full)
    );

    tch_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_q_push),
        .i_item  (s_front_item),
        .o_full  (s_q_full),
        .i_pop   (s_q_pop),
        .o_item  (s_back_item),
        .o_empty (s_q_empty)
    );

    tch_back #(
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (s_q_empty),
        .o_q_pop   (s_q_pop),
        .i_q_item  (s_back_item),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_heading (o_heading),
        .o_status  (o_status)
    );

    assign s_err_nonzero = !empty && o_status != tch_pkg::STAT_OK && o_heading != '0;

    `ASSERT_NEVER(a_push_into_full, i_clk, i_rst_n, s_q_push && s_q_full, "push into full queue")
    `ASSERT_NEVER(a_pop_from_empty, i_clk, i_rst_n, s_q_pop && s_q_empty, "pop from empty queue")
    `ASSERT_NEVER(a_err_heading, i_clk, i_rst_n, s_err_nonzero, "error with nonzero heading")
    `ASSERT_ALWAYS(a_status_code, i_clk, i_rst_n, empty || o_status != 2'd3, "undefined status")

endmodule

`default_nettype wire
